// ===== rtl/twr_tof_pkg.sv =====
// Shared widths and pipeline payload types for the two-way ranging solver.
`timescale 1ns / 1ps
package twr_tof_pkg;

  localparam int STAMP_BITS = 40;
  localparam int HALF_BITS  = STAMP_BITS / 2;
  localparam int TOF_BITS   = STAMP_BITS + 1;
  localparam int PROD_BITS  = 2 * STAMP_BITS;
  localparam int DEN_BITS   = STAMP_BITS + 2;
  localparam int QUO_BITS   = TOF_BITS;
  localparam int CMP_BITS   = DEN_BITS + QUO_BITS;

  localparam logic MODE_ASYM = 1'b0;
  localparam logic MODE_SYM  = 1'b1;

  // Item leaving the front end: sign and magnitude of the numerator plus control.
  typedef struct packed {
    logic                       sym;
    logic                       zero;
    logic                       neg;
    logic [PROD_BITS-1:0]       mag;
    logic [DEN_BITS-1:0]        den;
    logic signed [TOF_BITS-1:0] sym_tof;
  } front_t;

  // Control carried alongside the divider stages.
  typedef struct packed {
    logic                       sym;
    logic                       zero;
    logic                       neg;
    logic                       sat;
    logic [DEN_BITS-1:0]        den;
    logic signed [TOF_BITS-1:0] sym_tof;
  } div_ctl_t;

endpackage

// ===== rtl/two_way_ranging_tof_top.sv =====
// Top level of the double-sided two-way ranging time-of-flight solver.
`timescale 1ns / 1ps
// Takes the six 40-bit timestamps of one poll / acknowledge / final exchange per item
// and returns the time of flight in ticks, saturated to 41 bits signed. One item is
// accepted per cycle; each item passes from input to output register through four
// front stages (intervals, 20x20 partial products, product sums, numerator magnitude),
// one saturation check, 41 restoring divider stages (one quotient bit each) and the
// output register. The whole pipeline halts while a waiting result is stalled.
// ranging_mode selects the asymmetric formula (0) or the symmetric average (1); it is
// sampled as each item enters, and should be written only while the block is empty.
module two_way_ranging_tof_top import twr_tof_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_ranging_mode_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [STAMP_BITS-1:0]      poll_sent_i,
  input  logic [STAMP_BITS-1:0]      poll_received_i,
  input  logic [STAMP_BITS-1:0]      ack_sent_i,
  input  logic [STAMP_BITS-1:0]      ack_received_i,
  input  logic [STAMP_BITS-1:0]      final_sent_i,
  input  logic [STAMP_BITS-1:0]      final_received_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [TOF_BITS-1:0] flight_time_o,
  output logic                       divide_by_zero_o
);

  localparam logic signed [TOF_BITS-1:0] TOF_MAX = {1'b0, {(TOF_BITS-1){1'b1}}};
  localparam logic signed [TOF_BITS-1:0] TOF_MIN = {1'b1, {(TOF_BITS-1){1'b0}}};
  localparam logic [QUO_BITS-1:0]        POS_LIM = {1'b0, {(QUO_BITS-1){1'b1}}};
  localparam logic [QUO_BITS-1:0]        NEG_LIM = {1'b1, {(QUO_BITS-1){1'b0}}};

  logic                       mode_q;
  logic                       adv;
  logic                       fv;
  front_t                     fitem;
  logic                       dv;
  div_ctl_t                   dctl;
  logic [QUO_BITS-1:0]        dquo;
  logic                       out_valid_q;
  logic signed [TOF_BITS-1:0] tof_q, tof_d;
  logic                       dbz_q, dbz_d;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ASYM;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_ranging_mode_i;
    end
  end

  twr_tof_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (in_valid_i),
    .mode_i          (mode_q),
    .poll_sent_i     (poll_sent_i),
    .poll_received_i (poll_received_i),
    .ack_sent_i      (ack_sent_i),
    .ack_received_i  (ack_received_i),
    .final_sent_i    (final_sent_i),
    .final_received_i(final_received_i),
    .valid_o         (fv),
    .item_o          (fitem)
  );

  twr_tof_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(fv),
    .item_i (fitem),
    .valid_o(dv),
    .ctl_o  (dctl),
    .quo_o  (dquo)
  );

  always_comb begin
    dbz_d = 1'b0;
    if (dctl.sym) begin
      tof_d = dctl.sym_tof;
    end else if (dctl.zero) begin
      tof_d = '0;
      dbz_d = 1'b1;
    end else if (dctl.neg) begin
      tof_d = (dctl.sat || dquo > NEG_LIM) ? TOF_MIN : -$signed(dquo);
    end else begin
      tof_d = (dctl.sat || dquo > POS_LIM) ? TOF_MAX : $signed(dquo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tof_q <= tof_d;
      dbz_q <= dbz_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign flight_time_o    = tof_q;
  assign divide_by_zero_o = dbz_q;

  // In the asymmetric mode a zero denominator forces a zero time of flight.
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (flight_time_o == '0))
    else $error("divide by zero flagged with nonzero result");

endmodule

// ===== rtl/twr_tof_front.sv =====
// Interval, product and numerator stages of the ranging solver.
`timescale 1ns / 1ps
module twr_tof_front import twr_tof_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic                  mode_i,
  input  logic [STAMP_BITS-1:0] poll_sent_i,
  input  logic [STAMP_BITS-1:0] poll_received_i,
  input  logic [STAMP_BITS-1:0] ack_sent_i,
  input  logic [STAMP_BITS-1:0] ack_received_i,
  input  logic [STAMP_BITS-1:0] final_sent_i,
  input  logic [STAMP_BITS-1:0] final_received_i,
  output logic                  valid_o,
  output front_t                item_o
);

  // Stage 1: intervals and symmetric sums.
  logic                  v1_q;
  logic                  mode1_q;
  logic [STAMP_BITS-1:0] rnd1_q, rnd2_q, rep1_q, rep2_q;
  logic [DEN_BITS-1:0]   pos_q, ngs_q;

  // Stage 2: partial products, denominator, symmetric difference.
  logic                  v2_q;
  logic                  mode2_q;
  logic [STAMP_BITS-1:0] a_ll_q, a_lh_q, a_hl_q, a_hh_q;
  logic [STAMP_BITS-1:0] b_ll_q, b_lh_q, b_hl_q, b_hh_q;
  logic [DEN_BITS-1:0]   den2_q;
  logic [DEN_BITS:0]     sdiff_q;

  // Stage 3: full products and symmetric result.
  logic                       v3_q;
  logic                       mode3_q;
  logic [PROD_BITS-1:0]       pa_q, pb_q;
  logic [DEN_BITS-1:0]        den3_q;
  logic signed [TOF_BITS-1:0] stof3_q;

  // Stage 4: output register.
  logic   v4_q;
  front_t item_q;

  logic [STAMP_BITS:0]   a_mid, b_mid;
  logic [DEN_BITS:0]     sabs;
  logic [TOF_BITS-1:0]   smag;
  logic [DEN_BITS-1:0]   den_d;

  function automatic logic [STAMP_BITS-1:0] mul_half(input logic [HALF_BITS-1:0] a,
                                                     input logic [HALF_BITS-1:0] b);
    return {{HALF_BITS{1'b0}}, a} * {{HALF_BITS{1'b0}}, b};
  endfunction

  assign den_d = {2'b00, rnd1_q} + {2'b00, rnd2_q} + {2'b00, rep1_q} + {2'b00, rep2_q};
  assign a_mid = {1'b0, a_lh_q} + {1'b0, a_hl_q};
  assign b_mid = {1'b0, b_lh_q} + {1'b0, b_hl_q};
  assign sabs  = sdiff_q[DEN_BITS] ? -sdiff_q : sdiff_q;
  assign smag  = sabs[DEN_BITS:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode1_q <= mode_i;
      rnd1_q  <= ack_received_i - poll_sent_i;
      rep1_q  <= ack_sent_i - poll_received_i;
      rnd2_q  <= final_received_i - ack_sent_i;
      rep2_q  <= final_sent_i - ack_received_i;
      pos_q   <= {2'b00, ack_received_i} + {2'b00, poll_received_i}
               + {2'b00, final_received_i} + {2'b00, ack_received_i};
      ngs_q   <= {2'b00, poll_sent_i} + {2'b00, ack_sent_i}
               + {2'b00, ack_sent_i} + {2'b00, final_sent_i};

      mode2_q <= mode1_q;
      a_ll_q  <= mul_half(rnd1_q[HALF_BITS-1:0], rnd2_q[HALF_BITS-1:0]);
      a_lh_q  <= mul_half(rnd1_q[HALF_BITS-1:0], rnd2_q[STAMP_BITS-1:HALF_BITS]);
      a_hl_q  <= mul_half(rnd1_q[STAMP_BITS-1:HALF_BITS], rnd2_q[HALF_BITS-1:0]);
      a_hh_q  <= mul_half(rnd1_q[STAMP_BITS-1:HALF_BITS], rnd2_q[STAMP_BITS-1:HALF_BITS]);
      b_ll_q  <= mul_half(rep1_q[HALF_BITS-1:0], rep2_q[HALF_BITS-1:0]);
      b_lh_q  <= mul_half(rep1_q[HALF_BITS-1:0], rep2_q[STAMP_BITS-1:HALF_BITS]);
      b_hl_q  <= mul_half(rep1_q[STAMP_BITS-1:HALF_BITS], rep2_q[HALF_BITS-1:0]);
      b_hh_q  <= mul_half(rep1_q[STAMP_BITS-1:HALF_BITS], rep2_q[STAMP_BITS-1:HALF_BITS]);
      den2_q  <= den_d;
      sdiff_q <= {1'b0, pos_q} - {1'b0, ngs_q};

      mode3_q <= mode2_q;
      pa_q    <= {a_hh_q, {STAMP_BITS{1'b0}}}
               + {{(HALF_BITS-1){1'b0}}, a_mid, {HALF_BITS{1'b0}}}
               + {{STAMP_BITS{1'b0}}, a_ll_q};
      pb_q    <= {b_hh_q, {STAMP_BITS{1'b0}}}
               + {{(HALF_BITS-1){1'b0}}, b_mid, {HALF_BITS{1'b0}}}
               + {{STAMP_BITS{1'b0}}, b_ll_q};
      den3_q  <= den2_q;
      stof3_q <= sdiff_q[DEN_BITS] ? -$signed(smag) : $signed(smag);

      item_q.sym     <= (mode3_q == MODE_SYM);
      item_q.zero    <= (den3_q == '0);
      item_q.neg     <= (pa_q < pb_q);
      item_q.mag     <= (pa_q < pb_q) ? (pb_q - pa_q) : (pa_q - pb_q);
      item_q.den     <= den3_q;
      item_q.sym_tof <= stof3_q;
    end
  end

  assign valid_o = v4_q;
  assign item_o  = item_q;

  // All four intervals are zero when the sum is zero, so both products vanish.
  a_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && item_q.zero) |-> (item_q.mag == '0))
    else $error("zero denominator with nonzero numerator");

endmodule

// ===== rtl/twr_tof_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module twr_tof_div import twr_tof_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  front_t              item_i,
  output logic                valid_o,
  output div_ctl_t            ctl_o,
  output logic [QUO_BITS-1:0] quo_o
);

  logic                 v_q   [0:QUO_BITS];
  div_ctl_t             ctl_q [0:QUO_BITS];
  logic [PROD_BITS-1:0] rem_q [0:QUO_BITS];
  logic [QUO_BITS-1:0]  quo_q [0:QUO_BITS];

  // Entry stage: a quotient of 2^41 or more saturates in any case.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q[0].sym     <= item_i.sym;
      ctl_q[0].zero    <= item_i.zero;
      ctl_q[0].neg     <= item_i.neg;
      ctl_q[0].sat     <= ({{(CMP_BITS-PROD_BITS){1'b0}}, item_i.mag}
                           >= {item_i.den, {QUO_BITS{1'b0}}});
      ctl_q[0].den     <= item_i.den;
      ctl_q[0].sym_tof <= item_i.sym_tof;
      rem_q[0]         <= item_i.mag;
      quo_q[0]         <= '0;
    end
  end

  for (genvar j = 1; j <= QUO_BITS; j++) begin : g_stage
    localparam int K = QUO_BITS - j;
    logic [CMP_BITS-1:0]  cand;
    logic [CMP_BITS-1:0]  remx;
    logic [CMP_BITS-1:0]  trial;
    logic                 ge;
    logic [QUO_BITS-1:0]  quo_d;

    assign cand  = {{QUO_BITS{1'b0}}, ctl_q[j-1].den} << K;
    assign remx  = {{(CMP_BITS-PROD_BITS){1'b0}}, rem_q[j-1]};
    assign trial = remx - cand;
    assign ge    = (remx >= cand);

    always_comb begin
      quo_d    = quo_q[j-1];
      quo_d[K] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (adv_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ctl_q[j] <= ctl_q[j-1];
        rem_q[j] <= ge ? trial[PROD_BITS-1:0] : rem_q[j-1];
        quo_q[j] <= quo_d;
      end
    end
  end

  assign valid_o = v_q[QUO_BITS];
  assign ctl_o   = ctl_q[QUO_BITS];
  assign quo_o   = quo_q[QUO_BITS];

  // An unsaturated division must leave a remainder below the divisor.
  a_rem_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[QUO_BITS] && !ctl_q[QUO_BITS].sat && !ctl_q[QUO_BITS].zero)
      |-> ({{(PROD_BITS-DEN_BITS){1'b0}}, ctl_q[QUO_BITS].den} > rem_q[QUO_BITS]))
    else $error("divider remainder not below divisor");

endmodule
